@@ src/parallel_port_byte_writer_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the parallel port byte writer
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PARALLEL_PORT_BYTE_WRITER_UNIT_MACROS_SVH
`define PARALLEL_PORT_BYTE_WRITER_UNIT_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge out of reset
`define PBW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never occurs out of reset
`define PBW_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PBW_ASSERT(lbl, clk, rst_n, prop, msg)

`define PBW_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ src/pbw_pkg.sv @@
// ---------------------------------------------------------------------------
// pbw_pkg
// Types and constants shared by the parallel port byte writer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbw_pkg;

	localparam int unsigned SENT_W = 25;
	localparam int unsigned TMO_W  = 31;

	localparam logic [SENT_W-1:0] MAX_BYTES   = 25'd16777216;
	localparam logic [TMO_W-1:0]  TMO_RESET   = 31'd300;
	localparam logic [TMO_W-1:0]  IDLE_SAT    = 31'h7FFF_FFFF;

	// status line decode
	localparam logic [7:0]  STAT_FLOATING    = 8'hFF;
	localparam int unsigned STAT_NOT_BUSY    = 7;
	localparam int unsigned STAT_PAPER_OUT   = 5;
	localparam int unsigned STAT_SELECTED    = 4;
	localparam int unsigned STAT_NOT_ERROR   = 3;

	// control lines
	localparam logic [3:0] CTL_IDLE   = 4'hC;
	localparam logic [3:0] CTL_STROBE = 4'h1;

	typedef enum logic [2:0] {
		CODE_OK       = 3'd0,
		CODE_FAULT    = 3'd1,
		CODE_TIMEOUT  = 3'd2,
		CODE_OVERRUN  = 3'd3,
		CODE_TOO_LONG = 3'd4
	} pbw_code_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       is_last;
		logic [7:0] status_lines;
	} pbw_in_t;

	typedef struct packed {
		logic [7:0]        data_pins;
		logic [3:0]        control_pins;
		logic              transfer_done;
		logic [2:0]        status_code;
		logic [SENT_W-1:0] bytes_sent;
		logic              run_end;
	} pbw_out_t;

	// one queued job: either a strobe pair or a single status beat
	typedef struct packed {
		logic              strobe;
		logic [7:0]        data;
		logic              done;
		pbw_code_t         code;
		logic [SENT_W-1:0] sent;
	} pbw_job_t;

endpackage

`default_nettype wire

@@ src/pbw_front.sv @@
// ---------------------------------------------------------------------------
// pbw_front
// Accepts byte offers and ticks, keeps the transfer state and posts one job
// per item that produces results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "parallel_port_byte_writer_unit_macros.svh"

module pbw_front import pbw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pbw_in_t          in_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [TMO_W-1:0] cfg_data,
	input  wire logic             q_full,
	output logic                  q_push,
	output pbw_job_t              q_job
);

	logic              pending_q;
	logic [7:0]        held_byte_q;
	logic              held_last_q;
	logic [TMO_W-1:0]  idle_q;
	logic [SENT_W-1:0] sent_q;
	logic [7:0]        dout_q;
	logic [TMO_W-1:0]  timeout_q;

	logic              acc;
	logic [7:0]        st;
	logic              present, port_ok, fault, tmo_hit;
	logic [TMO_W-1:0]  idle_inc;
	logic [SENT_W-1:0] sent_inc;

	assign in_ready  = !q_full;
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && in_ready;

	// status decode
	assign st       = in_data.status_lines;
	assign present  = st != STAT_FLOATING;
	assign port_ok  = present && st[STAT_NOT_BUSY] && st[STAT_SELECTED]
		&& !st[STAT_PAPER_OUT] && st[STAT_NOT_ERROR];
	assign fault    = !present || st[STAT_PAPER_OUT] || !st[STAT_NOT_ERROR]
		|| !st[STAT_SELECTED];
	assign idle_inc = (idle_q == IDLE_SAT) ? idle_q : idle_q + 1'b1;
	assign tmo_hit  = idle_inc >= timeout_q;
	assign sent_inc = sent_q + 1'b1;

	// job decision
	always_comb begin
		q_push        = 1'b0;
		q_job.strobe  = 1'b0;
		q_job.data    = dout_q;
		q_job.done    = 1'b0;
		q_job.code    = CODE_OK;
		q_job.sent    = sent_q;
		if (acc) begin
			if (!in_data.kind) begin
				if (pending_q) begin
					q_push     = 1'b1;
					q_job.code = CODE_OVERRUN;
				end else if (sent_q >= MAX_BYTES) begin
					q_push     = 1'b1;
					q_job.code = CODE_TOO_LONG;
				end
			end else if (pending_q) begin
				if (port_ok) begin
					q_push       = 1'b1;
					q_job.strobe = 1'b1;
					q_job.data   = held_byte_q;
					q_job.done   = held_last_q;
					q_job.sent   = sent_inc;
				end else if (fault) begin
					q_push     = 1'b1;
					q_job.done = 1'b1;
					q_job.code = CODE_FAULT;
				end else if (tmo_hit) begin
					q_push     = 1'b1;
					q_job.done = 1'b1;
					q_job.code = CODE_TIMEOUT;
				end
			end
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TMO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			held_byte_q <= '0;
			held_last_q <= 1'b0;
			idle_q      <= '0;
			sent_q      <= '0;
			dout_q      <= '0;
		end else if (acc) begin
			if (!in_data.kind) begin
				if (pending_q) begin
					// overrun: state unchanged
				end else if (sent_q >= MAX_BYTES) begin
					sent_q <= '0;
				end else begin
					pending_q   <= 1'b1;
					held_byte_q <= in_data.data_byte;
					held_last_q <= in_data.is_last;
					idle_q      <= '0;
				end
			end else if (pending_q) begin
				if (port_ok) begin
					dout_q      <= held_byte_q;
					pending_q   <= 1'b0;
					idle_q      <= '0;
					sent_q      <= held_last_q ? '0 : sent_inc;
					held_last_q <= 1'b0;
				end else if (fault || tmo_hit) begin
					pending_q   <= 1'b0;
					held_last_q <= 1'b0;
					idle_q      <= '0;
					sent_q      <= '0;
				end else begin
					idle_q <= idle_inc;
				end
			end
		end
	end

	`PBW_ASSERT(a_idle_only_pending, clk, arst_n, !pending_q |-> idle_q == '0, "idle count runs with no byte pending")
	`PBW_ASSERT(a_sent_bound, clk, arst_n, sent_q <= MAX_BYTES, "sent count beyond limit")
	`PBW_NEVER(a_push_when_full, clk, arst_n, q_push && q_full, "job posted into a full queue")

endmodule

`default_nettype wire

@@ src/pbw_job_fifo.sv @@
// ---------------------------------------------------------------------------
// pbw_job_fifo
// Short show-ahead queue of jobs between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbw_job_fifo import pbw_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire pbw_job_t push_job,
	input  wire logic     pop,
	output logic          full,
	output logic          empty,
	output pbw_job_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pbw_job_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/pbw_back.sv @@
// ---------------------------------------------------------------------------
// pbw_back
// Expands queued jobs into result beats: a strobe job gives a strobe beat
// and a release beat, any other job one status beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "parallel_port_byte_writer_unit_macros.svh"

module pbw_back import pbw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_empty,
	input  wire pbw_job_t q_head,
	output logic          q_pop,
	output logic          out_valid,
	input  wire logic     out_ready,
	output pbw_out_t      out_data
);

	logic     out_valid_q;
	pbw_out_t out_q;
	logic     phase_q;
	logic     load;
	pbw_out_t beat;

	assign load      = !out_valid_q || out_ready;
	assign q_pop     = load && !q_empty && (!q_head.strobe || phase_q);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// beat formation
	always_comb begin
		beat.data_pins     = q_head.data;
		beat.control_pins  = CTL_IDLE;
		beat.transfer_done = q_head.done;
		beat.status_code   = q_head.code;
		beat.bytes_sent    = q_head.sent;
		beat.run_end       = 1'b1;
		if (q_head.strobe && !phase_q) begin
			beat.control_pins  = CTL_IDLE | CTL_STROBE;
			beat.transfer_done = 1'b0;
			beat.run_end       = 1'b0;
		end
	end

	// output register and beat phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				phase_q <= q_head.strobe && !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_q <= beat;
		end
	end

	`PBW_ASSERT(a_phase_has_job, clk, arst_n, phase_q |-> !q_empty && q_head.strobe, "release beat without its strobe job")
	`PBW_ASSERT(a_strobe_not_end, clk, arst_n, out_valid_q && out_q.control_pins[0] |-> !out_q.run_end, "strobe beat marked as run end")
	`PBW_NEVER(a_pop_empty, clk, arst_n, q_pop && q_empty, "pop from empty job queue")

endmodule

`default_nettype wire

@@ src/parallel_port_byte_writer_unit.sv @@
// An accepted item's job is written into the job queue, and the back end registers its
// beats into the output register. Throughput: one item per cycle at the input while the
// queue is not full; the output register emits one beat per cycle while out_ready is high,
// so a strobed byte (two beats) holds it longer; the job queue (DEPTH entries) absorbs that.
// Reset: arst_n clears all transfer state, the queue and the output; timeout is 300.
// ---------------------------------------------------------------------------
// parallel_port_byte_writer_unit
// Host side of a compatibility mode parallel port write: front part decides,
// back part drives data and strobe beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module parallel_port_byte_writer_unit import pbw_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pbw_in_t          in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pbw_out_t              out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [TMO_W-1:0] cfg_data
);

	logic     q_full, q_empty, q_push, q_pop;
	pbw_job_t q_job, q_head;

	// decision front
	pbw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	// job queue
	pbw_job_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// beat back end
	pbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
